// ----- sv/pdhc_pkg.sv -----
package pdhc_pkg;

  localparam int unsigned BlkBytes   = 532;
  localparam int unsigned StatBytes  = 4;
  localparam int unsigned RdBytes    = 536;
  localparam int unsigned DefBlocks  = 64;
  localparam logic [7:0]  ReplyGo    = 8'h55;
  localparam logic [23:0] InfoBlock  = 24'hFFFFFF;
  localparam logic [19:0] DefDelay   = 20'd24000;

  typedef enum logic [2:0] {
    CMD_CTRL  = 3'd0,
    CMD_STATE = 3'd1,
    CMD_DRD   = 3'd2,
    CMD_REPLY = 3'd3,
    CMD_DWR   = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HS        = 3'd1,
    PH_FRAME     = 3'd2,
    PH_FRAME_END = 3'd3,
    PH_READ      = 3'd4,
    PH_WR_DATA   = 3'd5,
    PH_WR_END    = 3'd6,
    PH_STATUS    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_INFO,
    SRC_DISK
  } rsrc_e;

  typedef enum logic [1:0] {
    REG_ATTACHED = 2'd0,
    REG_BLOCKS   = 2'd1,
    REG_DELAY    = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_CLEAR,
    ST_COPY
  } seq_e;

  // Byte of the synthesized info block at offset idx within the block body.
  function automatic logic [7:0] info_byte(logic [9:0] idx, logic [23:0] n);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      10'd0:  b = 8'h50;
      10'd1:  b = 8'h52;
      10'd2:  b = 8'h4F;
      10'd3:  b = 8'h46;
      10'd4:  b = 8'h49;
      10'd5:  b = 8'h4C;
      10'd6:  b = 8'h45;
      10'd7, 10'd8, 10'd9, 10'd10, 10'd11, 10'd12: b = 8'h20;
      10'd16: b = 8'h03;
      10'd17: b = 8'h98;
      10'd18: b = n[23:16];
      10'd19: b = n[15:8];
      10'd20: b = n[7:0];
      10'd21: b = 8'h02;
      10'd22: b = 8'h14;
      10'd23: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/pdhc_store.sv -----
module pdhc_store import pdhc_pkg::*; #(
  parameter int unsigned Depth = DefBlocks * BlkBytes,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/parallel_disk_handshake_controller.sv -----
// Byte-wide parallel disk controller. One request is accepted when start is
// high and busy is low; its result appears on read_data_o and busy_res_o
// with done_o high for one cycle, and the receiver cannot stall it. Each request
// is processed in the cycle after it is accepted and its result is shown in the
// cycle after that, so busy is high only while a request is processed or the
// buffer is copied, and a new request can be accepted while a result is shown.
// Block data reads come straight from the disk store, whose registered read is
// already under way when the request arrives. Block write data goes into a
// 532-byte buffer; the last byte of a write to a valid block holds busy while
// the buffer is copied into the disk store. After reset the block clears the
// disk store, one byte a cycle, and accepts no request until it is done;
// configuration writes are taken at any time.
module parallel_disk_handshake_controller import pdhc_pkg::*; #(
  parameter int unsigned BLOCKS = DefBlocks
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [7:0]  value_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        busy_res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);

  localparam int unsigned Depth = BLOCKS * BlkBytes;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned BufW  = $clog2(BlkBytes);
  localparam int unsigned BlkW  = $clog2(BLOCKS + 1) > 7 ? $clog2(BLOCKS + 1) : 7;

  logic        attached_q;
  logic [6:0]  blocks_q;
  logic [19:0] delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= 1'b1;
      blocks_q   <= 7'd64;
      delay_q    <= DefDelay;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACHED: attached_q <= cfg_data_i[0];
        REG_BLOCKS:   blocks_q   <= cfg_data_i[6:0];
        REG_DELAY:    delay_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [BlkW-1:0] eff_blocks;
  always_comb begin
    if (BlkW'(blocks_q) < BlkW'(BLOCKS)) eff_blocks = BlkW'(blocks_q);
    else eff_blocks = BlkW'(BLOCKS);
  end

  seq_e        seq_q, seq_d;
  phase_e      phase_q;
  logic        cmd_low_q;
  logic [7:0]  pstate_q;
  phase_e      after_q;
  logic [7:0]  reply_q;
  logic [7:0]  frame_q [4];
  logic [2:0]  fidx_q;
  logic [9:0]  tlen_q, tidx_q;
  logic        busy_lvl_q;
  logic [19:0] dcnt_q;
  rsrc_e       rsrc_q;
  logic        blk_ok_q;
  logic [BlkW-1:0] info_n_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] clr_q;
  logic [9:0]  cp_q;
  logic        done_q;
  logic [7:0]  rd_q;
  cmd_e        cmd_q;
  logic [7:0]  val_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;

  logic             buf_we;
  logic [BufW-1:0]  buf_waddr, buf_raddr;
  logic [7:0]       buf_rdata;

  pdhc_store #(.Depth(Depth), .AddrW(AddrW)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pdhc_store #(.Depth(BlkBytes), .AddrW(BufW)) u_buf (
    .clk_i,
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (val_q),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  logic [23:0] fblk;
  assign fblk = {frame_q[1], frame_q[2], frame_q[3]};
  logic        fblk_ok;
  assign fblk_ok = (fblk != InfoBlock) && (fblk < 24'(eff_blocks));

  logic [9:0] body_idx;
  assign body_idx = tidx_q - 10'(StatBytes);
  assign raddr = base_q + AddrW'(body_idx);

  logic accept;
  assign accept = start && !busy;
  assign busy = (seq_q != ST_IDLE);

  logic wr_byte;
  assign wr_byte = (seq_q == ST_MEM) && attached_q && (cmd_q == CMD_DWR) &&
                   (phase_q == PH_WR_DATA) && (tidx_q < tlen_q);

  logic commit;
  assign commit = wr_byte && (tidx_q + 10'd1 >= tlen_q) && fblk_ok;

  assign buf_we    = wr_byte;
  assign buf_waddr = BufW'(tidx_q);
  assign buf_raddr = BufW'(cp_q);

  always_comb begin
    we    = 1'b0;
    waddr = base_q + AddrW'(cp_q - 10'd1);
    wdata = buf_rdata;
    if (seq_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = 8'h00;
    end else if (seq_q == ST_COPY && cp_q != '0) begin
      we = 1'b1;
    end
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      ST_CLEAR: if (clr_q == AddrW'(Depth - 1)) seq_d = ST_IDLE;
      ST_IDLE:  if (accept) seq_d = ST_MEM;
      ST_MEM:   seq_d = commit ? ST_COPY : ST_IDLE;
      ST_COPY:  if (cp_q == 10'(BlkBytes)) seq_d = ST_IDLE;
      default:  seq_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= ST_CLEAR;
      clr_q <= '0;
      cp_q  <= '0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (seq_q == ST_COPY) cp_q <= cp_q + 10'd1;
      else cp_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cmd_low_q  <= 1'b0;
      pstate_q   <= 8'h00;
      after_q    <= PH_IDLE;
      reply_q    <= 8'h00;
      fidx_q     <= '0;
      tlen_q     <= '0;
      tidx_q     <= '0;
      busy_lvl_q <= 1'b0;
      dcnt_q     <= '0;
      rsrc_q     <= SRC_ZERO;
      blk_ok_q   <= 1'b0;
      info_n_q   <= '0;
      base_q     <= '0;
      done_q     <= 1'b0;
      rd_q       <= 8'hFF;
    end else begin
      done_q <= 1'b0;
      if (seq_q == ST_MEM) begin
        done_q <= 1'b1;
        rd_q   <= 8'hFF;
        if (attached_q) begin
          case (cmd_q)
            CMD_CTRL: begin
              if (!val_q[4] != cmd_low_q) begin
                cmd_low_q <= !val_q[4];
                if (!val_q[4]) begin
                  if (phase_q != PH_FRAME_END && phase_q != PH_WR_END) begin
                    pstate_q <= 8'h01;
                    after_q  <= PH_FRAME;
                  end
                  phase_q    <= PH_HS;
                  busy_lvl_q <= 1'b1;
                end else if (phase_q == PH_HS && reply_q == ReplyGo &&
                             after_q == PH_READ && delay_q != '0) begin
                  phase_q <= PH_READ;
                  tidx_q  <= '0;
                  dcnt_q  <= delay_q;
                end else begin
                  busy_lvl_q <= 1'b0;
                  if (phase_q == PH_HS) begin
                    if (reply_q == ReplyGo) begin
                      phase_q <= after_q;
                      unique case (after_q)
                        PH_FRAME: fidx_q <= '0;
                        PH_READ:  tidx_q <= '0;
                        PH_WR_DATA: begin
                          tidx_q <= '0;
                          tlen_q <= 10'(BlkBytes);
                        end
                        PH_STATUS: begin
                          tidx_q <= '0;
                          tlen_q <= 10'(StatBytes);
                          rsrc_q <= SRC_ZERO;
                        end
                        default: ;
                      endcase
                    end else begin
                      phase_q <= PH_IDLE;
                    end
                  end
                end
              end
            end
            CMD_STATE: rd_q <= (phase_q == PH_HS) ? pstate_q : 8'hFF;
            CMD_DRD: begin
              if ((phase_q == PH_READ || phase_q == PH_STATUS) && tidx_q < tlen_q) begin
                tidx_q <= tidx_q + 10'd1;
                if (tidx_q < 10'(StatBytes)) begin
                  rd_q <= (tidx_q == 10'd1 && rsrc_q == SRC_ZERO && phase_q == PH_READ &&
                           !blk_ok_q) ? 8'h02 : 8'h00;
                end else if (rsrc_q == SRC_INFO) begin
                  rd_q <= info_byte(body_idx, 24'(info_n_q));
                end else if (rsrc_q == SRC_DISK) begin
                  rd_q <= rdata;
                end else begin
                  rd_q <= 8'h00;
                end
                if (phase_q == PH_STATUS && tidx_q + 10'd1 >= tlen_q) phase_q <= PH_IDLE;
              end
            end
            CMD_REPLY: reply_q <= val_q;
            CMD_DWR: begin
              if (phase_q == PH_FRAME) begin
                if (fidx_q < 3'd6) begin
                  fidx_q <= fidx_q + 3'd1;
                  if (fidx_q == 3'd5) begin
                    phase_q  <= PH_FRAME_END;
                    tidx_q   <= '0;
                    base_q   <= AddrW'(fblk[BlkW-1:0]) * AddrW'(BlkBytes);
                    blk_ok_q <= fblk_ok;
                    info_n_q <= eff_blocks;
                    if (frame_q[0] == 8'h00) begin
                      tlen_q   <= 10'(RdBytes);
                      pstate_q <= 8'h02;
                      after_q  <= PH_READ;
                      rsrc_q   <= (fblk == InfoBlock) ? SRC_INFO :
                                  (fblk_ok ? SRC_DISK : SRC_ZERO);
                    end else begin
                      tlen_q   <= 10'(BlkBytes);
                      pstate_q <= 8'h03;
                      after_q  <= PH_WR_DATA;
                    end
                  end
                end
              end else if (phase_q == PH_WR_DATA && tidx_q < tlen_q) begin
                tidx_q <= tidx_q + 10'd1;
                if (tidx_q + 10'd1 >= tlen_q) begin
                  pstate_q <= 8'h06;
                  after_q  <= PH_STATUS;
                  phase_q  <= PH_WR_END;
                end
              end
            end
            CMD_TICK: begin
              if (dcnt_q != '0) begin
                dcnt_q <= dcnt_q - 20'd1;
                if (dcnt_q == 20'd1) busy_lvl_q <= 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_q == ST_MEM && attached_q && cmd_q == CMD_DWR &&
        phase_q == PH_FRAME && fidx_q < 3'd4) begin
      frame_q[fidx_q[1:0]] <= val_q;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rd_q;
  assign busy_res_o  = busy_lvl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> seq_q != ST_MEM)
    else $error("result shown while request still processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> seq_q == ST_MEM)
    else $error("accepted request not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (seq_q == ST_MEM) |=> done_o)
    else $error("processed request gave no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) tidx_q <= 10'(RdBytes))
    else $error("transfer index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (seq_q == ST_COPY) |-> cp_q <= 10'(BlkBytes))
    else $error("copy counter out of range");

endmodule

// ----- test/tb_parallel_disk_handshake_controller.sv -----
`timescale 1ns / 100ps

module tb_parallel_disk_handshake_controller import pdhc_pkg::*; ();

  localparam int unsigned StoreBytes = DefBlocks * BlkBytes;
  localparam int unsigned IdleLimit  = 200000;

  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
  } port_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command_i = '0;
  logic [7:0]  value_i = '0;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        busy_res_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  parallel_disk_handshake_controller uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .value_i, .done_o,
    .read_data_o, .busy_res_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  logic [7:0]  dev_name [13] = '{8'h50, 8'h52, 8'h4F, 8'h46, 8'h49, 8'h4C, 8'h45,
                                 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20};

  logic        m_attached;
  logic [6:0]  m_blocks;
  logic [19:0] m_delay;
  phase_e      m_phase;
  logic        m_cmd_low;
  logic [7:0]  m_presented;
  phase_e      m_next_phase;
  logic [7:0]  m_reply;
  logic [7:0]  m_frame [6];
  int unsigned m_frame_idx;
  logic [7:0]  m_buf [RdBytes];
  int unsigned m_len;
  int unsigned m_idx;
  logic        m_busy;
  logic [19:0] m_count;
  logic [7:0]  m_store [StoreBytes];

  port_result_t pending_results[$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  sent_items = 0;

  function automatic int unsigned eff_blocks();
    return (m_blocks < DefBlocks) ? m_blocks : DefBlocks;
  endfunction

  function automatic logic [23:0] frame_block();
    return {m_frame[1], m_frame[2], m_frame[3]};
  endfunction

  task automatic load_read_block(logic [23:0] blk);
    logic [23:0] n;
    n = 24'(eff_blocks());
    for (int i = 0; i < RdBytes; i++) m_buf[i] = 8'h00;
    if (blk == InfoBlock) begin
      for (int i = 0; i < 13; i++) m_buf[StatBytes + i] = dev_name[i];
      m_buf[StatBytes + 16] = 8'h03;
      m_buf[StatBytes + 17] = 8'h98;
      m_buf[StatBytes + 18] = n[23:16];
      m_buf[StatBytes + 19] = n[15:8];
      m_buf[StatBytes + 20] = n[7:0];
      m_buf[StatBytes + 21] = 8'h02;
      m_buf[StatBytes + 22] = 8'h14;
      m_buf[StatBytes + 23] = 8'h20;
    end else if (blk < n) begin
      for (int i = 0; i < BlkBytes; i++) m_buf[StatBytes + i] = m_store[blk * BlkBytes + i];
    end else begin
      m_buf[1] = 8'h02;
    end
    m_len = RdBytes;
    m_idx = 0;
  endtask

  task automatic enter_phase(phase_e p);
    m_phase = p;
    case (p)
      PH_FRAME: m_frame_idx = 0;
      PH_READ: m_idx = 0;
      PH_WR_DATA: begin
        m_idx = 0;
        m_len = BlkBytes;
      end
      PH_STATUS: begin
        for (int i = 0; i < StatBytes; i++) m_buf[i] = 8'h00;
        m_idx = 0;
        m_len = StatBytes;
      end
      default: ;
    endcase
  endtask

  task automatic model_control(logic [7:0] v);
    logic low;
    low = ~v[4];
    if (low != m_cmd_low) begin
      m_cmd_low = low;
      if (low) begin
        if (m_phase != PH_FRAME_END && m_phase != PH_WR_END) begin
          m_presented = 8'h01;
          m_next_phase = PH_FRAME;
        end
        m_phase = PH_HS;
        m_busy = 1'b1;
      end else if (m_phase == PH_HS && m_reply == ReplyGo && m_next_phase == PH_READ
                   && m_delay != 0) begin
        enter_phase(PH_READ);
        m_count = m_delay;
      end else begin
        m_busy = 1'b0;
        if (m_phase == PH_HS) begin
          if (m_reply == ReplyGo) enter_phase(m_next_phase);
          else m_phase = PH_IDLE;
        end
      end
    end
  endtask

  task automatic model_data_write(logic [7:0] v);
    logic [23:0] blk;
    if (m_phase == PH_FRAME) begin
      if (m_frame_idx < 6) begin
        m_frame[m_frame_idx] = v;
        m_frame_idx++;
        if (m_frame_idx == 6) begin
          if (m_frame[0] == 8'h00) begin
            load_read_block(frame_block());
            m_presented = 8'h02;
            m_next_phase = PH_READ;
          end else begin
            m_len = BlkBytes;
            m_idx = 0;
            m_presented = 8'h03;
            m_next_phase = PH_WR_DATA;
          end
          m_phase = PH_FRAME_END;
        end
      end
    end else if (m_phase == PH_WR_DATA && m_idx < m_len && m_idx < RdBytes) begin
      m_buf[m_idx] = v;
      m_idx++;
      if (m_idx >= m_len) begin
        blk = frame_block();
        if (blk != InfoBlock && blk < eff_blocks())
          for (int i = 0; i < BlkBytes; i++) m_store[blk * BlkBytes + i] = m_buf[i];
        m_presented = 8'h06;
        m_next_phase = PH_STATUS;
        m_phase = PH_WR_END;
      end
    end
  endtask

  task automatic predict_request(logic [2:0] cmd, logic [7:0] v);
    port_result_t r;
    r.read_data = 8'hFF;
    if (m_attached) begin
      case (cmd)
        CMD_CTRL: model_control(v);
        CMD_STATE: if (m_phase == PH_HS) r.read_data = m_presented;
        CMD_DRD: begin
          if ((m_phase == PH_READ || m_phase == PH_STATUS) && m_idx < m_len
              && m_idx < RdBytes) begin
            r.read_data = m_buf[m_idx];
            m_idx++;
            if (m_phase == PH_STATUS && m_idx >= m_len) m_phase = PH_IDLE;
          end
        end
        CMD_REPLY: m_reply = v;
        CMD_DWR: model_data_write(v);
        CMD_TICK: begin
          if (m_count != 0) begin
            m_count--;
            if (m_count == 0) m_busy = 1'b0;
          end
        end
        default: ;
      endcase
    end
    r.busy_res = m_busy;
    pending_results.push_back(r);
  endtask

  task automatic send_request(logic [2:0] cmd, logic [7:0] v);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(cmd, v);
    sent_items++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [19:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ATTACHED: m_attached = data[0];
      REG_BLOCKS: m_blocks = data[6:0];
      REG_DELAY: m_delay = data;
      default: ;
    endcase
  endtask

  task automatic handshake(logic [7:0] reply);
    send_request(CMD_CTRL, 8'($urandom()) & 8'hEF);
    send_request(CMD_STATE, 8'($urandom()));
    send_request(CMD_REPLY, reply);
    send_request(CMD_CTRL, 8'($urandom()) | 8'h10);
  endtask

  task automatic send_frame(logic [7:0] op, logic [23:0] blk);
    send_request(CMD_DWR, op);
    send_request(CMD_DWR, blk[23:16]);
    send_request(CMD_DWR, blk[15:8]);
    send_request(CMD_DWR, blk[7:0]);
    send_request(CMD_DWR, 8'($urandom()));
    send_request(CMD_DWR, 8'($urandom()));
  endtask

  task automatic read_block(logic [23:0] blk, int unsigned nbytes);
    handshake(ReplyGo);
    send_frame(8'h00, blk);
    handshake(ReplyGo);
    while (m_busy && m_attached && m_count != 0 && m_count < 64)
      send_request(CMD_TICK, 8'($urandom()));
    repeat (nbytes) send_request(CMD_DRD, 8'($urandom()));
  endtask

  task automatic write_block(logic [23:0] blk, int unsigned nbytes, bit random_data);
    handshake(ReplyGo);
    send_frame(8'(8'h01 + $urandom_range(0, 254)), blk);
    handshake(ReplyGo);
    for (int i = 0; i < nbytes; i++)
      send_request(CMD_DWR, random_data ? 8'($urandom()) : ((i % 2) ? 8'hFF : 8'h00));
    handshake(ReplyGo);
    repeat (5) send_request(CMD_DRD, 8'($urandom()));
  endtask

  task automatic test_idle_requests();
    send_request(CMD_STATE, 8'h00);
    send_request(CMD_DRD, 8'hFF);
    send_request(CMD_DWR, 8'hA5);
    send_request(CMD_TICK, 8'h5A);
    send_request(3'd6, 8'hFF);
    send_request(3'd7, 8'h00);
    handshake(8'h54);
    handshake(8'hFF);
  endtask

  task automatic test_block_transfers();
    write_reg(REG_DELAY, 20'd3);
    write_block(24'd3, BlkBytes, 1'b1);
    read_block(24'd3, RdBytes + 2);
    read_block(24'd63, 40);
    read_block(24'd0, 8);
  endtask

  task automatic test_info_and_range();
    write_reg(REG_BLOCKS, 20'd127);
    read_block(InfoBlock, 36);
    write_reg(REG_BLOCKS, 20'd0);
    read_block(InfoBlock, 36);
    read_block(24'd0, 8);
    write_block(InfoBlock, BlkBytes, 1'b0);
    write_reg(REG_BLOCKS, 20'd5);
    write_block(24'd5, BlkBytes, 1'b1);
    read_block(24'd5, 8);
    read_block(24'h123456, 8);
  endtask

  task automatic test_delay_extremes();
    write_reg(REG_DELAY, 20'd0);
    read_block(24'd3, 8);
    write_reg(REG_DELAY, 20'hFFFFF);
    read_block(24'd3, 4);
    repeat (4) send_request(CMD_TICK, 8'($urandom()));
    write_reg(REG_DELAY, 20'd2);
    read_block(24'd3, 4);
    write_reg(REG_DELAY, 20'd1);
    read_block(24'd1, 4);
  endtask

  task automatic test_detached();
    write_reg(REG_DELAY, 20'd5);
    handshake(ReplyGo);
    send_frame(8'h00, 24'd2);
    handshake(ReplyGo);
    write_reg(REG_ATTACHED, 20'd0);
    handshake(ReplyGo);
    repeat (4) send_request(CMD_TICK, 8'($urandom()));
    repeat (2) send_request(CMD_DRD, 8'($urandom()));
    write_reg(REG_ATTACHED, 20'd1);
    repeat (6) send_request(CMD_TICK, 8'($urandom()));
    send_request(CMD_DRD, 8'($urandom()));
  endtask

  task automatic test_random_traffic();
    logic [23:0] blk;
    int unsigned kind;
    int unsigned stop_at;
    write_reg(REG_BLOCKS, 20'd64);
    write_reg(REG_DELAY, 20'd2);
    stop_at = sent_items + 450;
    while (sent_items < stop_at) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: blk = InfoBlock;
        1: blk = 24'($urandom());
        2: blk = 24'($urandom_range(64, 127));
        default: blk = 24'($urandom_range(0, 63));
      endcase
      if (kind < 35) begin
        read_block(blk, $urandom_range(0, 40));
      end else if (kind < 45) begin
        write_block(blk, $urandom_range(0, 20), 1'b1);
      end else if (kind < 55) begin
        handshake($urandom_range(0, 1) ? ReplyGo : 8'($urandom()));
        send_frame($urandom_range(0, 1) ? 8'h00 : 8'($urandom()), blk);
        handshake(8'($urandom()));
      end else begin
        repeat ($urandom_range(1, 8)) send_request(3'($urandom()), 8'($urandom()));
      end
      if (kind % 17 == 0) begin
        write_reg(REG_BLOCKS, 20'($urandom_range(0, 127)));
        write_reg(REG_DELAY, 20'($urandom_range(0, 4)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    port_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: read_data %0h busy_res %0b",
               read_data_o, busy_res_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data expected %0h actual %0h", want.read_data, read_data_o);
          errors++;
        end
        if (busy_res_o !== want.busy_res) begin
          $error("busy_res expected %0b actual %0b", want.busy_res, busy_res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_parallel_disk_handshake_controller failed");
      $finish;
    end
  end

  initial begin
    m_attached = 1'b1;
    m_blocks = 7'd64;
    m_delay = DefDelay;
    m_phase = PH_IDLE;
    m_cmd_low = 1'b0;
    m_presented = 8'h00;
    m_next_phase = PH_IDLE;
    m_reply = 8'h00;
    m_frame_idx = 0;
    m_len = 0;
    m_idx = 0;
    m_busy = 1'b0;
    m_count = '0;
    foreach (m_frame[i]) m_frame[i] = 8'h00;
    foreach (m_buf[i]) m_buf[i] = 8'h00;
    foreach (m_store[i]) m_store[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_requests();
    test_block_transfers();
    test_info_and_range();
    test_delay_extremes();
    test_detached();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_parallel_disk_handshake_controller passed");
    end else begin
      $display("tb_parallel_disk_handshake_controller failed");
    end
    $finish;
  end

endmodule
